// ----- sv/svmm_pkg.sv -----
// Shared types and constants for the SVPWM min-max duty generator.
// No dependencies; every other file in this block imports this package.
package svmm_pkg;

  localparam int VOLT_W   = 16;
  localparam int DUTY_W   = 16;
  localparam int SECT_W   = 3;
  // Phase references span +/-44762 after the inverse Clarke transform.
  localparam int PHASE_W  = 17;

  localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
  localparam logic signed [17:0] SQRT3_Q15      = 18'sd56756;
  localparam logic signed [18:0] DUTY_CENTRE    = 19'sd16384;
  localparam logic signed [18:0] DUTY_FULL_IN   = 19'sd32768;
  localparam logic [15:0]        DUTY_FULL_OUT  = 16'hFFFF;
  localparam logic [30:0]        DUTY_ROUND     = 31'd16384;

  typedef logic [SECT_W-1:0] sector_t;

  localparam sector_t SECT_ZERO = 3'd0;
  localparam sector_t SECT_1    = 3'd1;
  localparam sector_t SECT_2    = 3'd2;
  localparam sector_t SECT_3    = 3'd3;
  localparam sector_t SECT_4    = 3'd4;
  localparam sector_t SECT_5    = 3'd5;
  localparam sector_t SECT_6    = 3'd6;

  typedef logic signed [PHASE_W-1:0] phase_t;
  typedef logic [DUTY_W-1:0]         duty_t;

endpackage

// ----- sv/svmm_if.sv -----
// Valid/ready channel interfaces for the voltage input and the duty result.
// Depends on svmm_pkg for field widths.
interface svmm_in_if import svmm_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] alpha_voltage;
  logic signed [VOLT_W-1:0] beta_voltage;

  modport source (output valid, alpha_voltage, beta_voltage, input ready);
  modport sink   (input valid, alpha_voltage, beta_voltage, output ready);
endinterface

interface svmm_out_if import svmm_pkg::*; ;
  logic    valid;
  logic    ready;
  duty_t   duty_phase_a;
  duty_t   duty_phase_b;
  duty_t   duty_phase_c;
  sector_t sector_number;

  modport source (output valid, duty_phase_a, duty_phase_b, duty_phase_c, sector_number,
                  input ready);
  modport sink   (input valid, duty_phase_a, duty_phase_b, duty_phase_c, sector_number,
                  output ready);
endinterface

// ----- sv/svmm_clarke.sv -----
// Pipeline stages one and two: Q15 products, then inverse Clarke phases and sector.
// Depends on svmm_pkg.
module svmm_clarke import svmm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [VOLT_W-1:0] alpha,
  input  logic signed [VOLT_W-1:0] beta,
  output logic                     out_vld,
  output phase_t                   pa,
  output phase_t                   pb,
  output phase_t                   pc,
  output sector_t                  sector
);

  logic signed [30:0]       prod_b_full;
  logic signed [31:0]       prod_a_full;
  logic                     v1_r;
  logic signed [VOLT_W-1:0] al_r;
  logic signed [VOLT_W-1:0] be_r;
  logic signed [30:0]       prod_b_r;
  logic signed [31:0]       prod_a_r;

  logic signed [30:0] bsum;
  logic signed [31:0] asum;
  logic signed [15:0] bterm;
  logic signed [16:0] s3a;
  logic signed [17:0] s3a_x;
  logic signed [17:0] ns3a_x;
  logic signed [17:0] be_x;
  logic signed [17:0] nbe_x;
  logic signed [16:0] neg_al;
  logic signed [16:0] half_a;
  phase_t             pa_nxt;
  phase_t             pb_nxt;
  phase_t             pc_nxt;
  sector_t            sect_nxt;

  logic    v2_r;
  phase_t  pa_r;
  phase_t  pb_r;
  phase_t  pc_r;
  sector_t sect_r;

  assign prod_b_full = 31'(beta) * 31'(SQRT3_HALF_Q15);
  assign prod_a_full = 32'(alpha) * 32'(SQRT3_Q15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al_r     <= alpha;
      be_r     <= beta;
      prod_b_r <= prod_b_full;
      prod_a_r <= prod_a_full;
    end
  end

  // Division by 32768 truncates toward zero, because negative products are biased first.
  always_comb begin
    bsum   = prod_b_r + (prod_b_r[30] ? 31'sd32767 : 31'sd0);
    asum   = prod_a_r + (prod_a_r[31] ? 32'sd32767 : 32'sd0);
    bterm  = bsum[30:15];
    s3a    = asum[31:15];
    neg_al = -{al_r[15], al_r};
    half_a = (neg_al + signed'({16'd0, neg_al[16]})) >>> 1;
    pa_nxt = {al_r[15], al_r};
    pb_nxt = half_a + {bterm[15], bterm};
    pc_nxt = half_a - {bterm[15], bterm};
  end

  always_comb begin
    s3a_x  = {s3a[16], s3a};
    ns3a_x = -s3a_x;
    be_x   = {{2{be_r[15]}}, be_r};
    nbe_x  = -be_x;
    if (al_r == '0 && be_r == '0) begin
      sect_nxt = SECT_ZERO;
    end else if (!be_r[15]) begin
      if (!al_r[15]) begin
        sect_nxt = (s3a_x >= be_x) ? SECT_1 : SECT_2;
      end else begin
        sect_nxt = (ns3a_x >= be_x) ? SECT_3 : SECT_2;
      end
    end else if (al_r[15]) begin
      sect_nxt = (ns3a_x >= nbe_x) ? SECT_4 : SECT_5;
    end else begin
      sect_nxt = (s3a_x >= nbe_x) ? SECT_6 : SECT_5;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      pc_r   <= pc_nxt;
      sect_r <= sect_nxt;
    end
  end

  assign out_vld = v2_r;
  assign pa      = pa_r;
  assign pb      = pb_r;
  assign pc      = pc_r;
  assign sector  = sect_r;

endmodule

// ----- sv/svmm_cm.sv -----
// Pipeline stage three: min-max common-mode offset of the three phase references.
// Depends on svmm_pkg.
module svmm_cm import svmm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_vld,
  input  phase_t  pa,
  input  phase_t  pb,
  input  phase_t  pc,
  input  sector_t sector,
  output logic    out_vld,
  output phase_t  pa_o,
  output phase_t  pb_o,
  output phase_t  pc_o,
  output phase_t  cm_o,
  output sector_t sector_o
);

  phase_t             mx;
  phase_t             mn;
  logic signed [17:0] mm_sum;
  logic signed [17:0] neg_sum;
  logic signed [17:0] cm_full;
  phase_t             cm_nxt;

  logic    v_r;
  phase_t  pa_r;
  phase_t  pb_r;
  phase_t  pc_r;
  phase_t  cm_r;
  sector_t sect_r;

  always_comb begin
    mx = pa;
    mn = pa;
    if (pb > mx) begin
      mx = pb;
    end
    if (pc > mx) begin
      mx = pc;
    end
    if (pb < mn) begin
      mn = pb;
    end
    if (pc < mn) begin
      mn = pc;
    end
    mm_sum  = {mx[PHASE_W-1], mx} + {mn[PHASE_W-1], mn};
    neg_sum = -mm_sum;
    cm_full = (neg_sum + signed'({17'd0, neg_sum[17]})) >>> 1;
    cm_nxt  = cm_full[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= pa;
      pb_r   <= pb;
      pc_r   <= pc;
      cm_r   <= cm_nxt;
      sect_r <= sector;
    end
  end

  assign out_vld  = v_r;
  assign pa_o     = pa_r;
  assign pb_o     = pb_r;
  assign pc_o     = pc_r;
  assign cm_o     = cm_r;
  assign sector_o = sect_r;

endmodule

// ----- sv/svmm_duty.sv -----
// Pipeline stage four: common-mode injection, clamping and scaling to 16-bit duty.
// Depends on svmm_pkg; its registers drive the result channel directly.
module svmm_duty import svmm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_vld,
  input  phase_t  pa,
  input  phase_t  pb,
  input  phase_t  pc,
  input  phase_t  cm,
  input  sector_t sector,
  output logic    out_vld,
  output duty_t   duty_a,
  output duty_t   duty_b,
  output duty_t   duty_c,
  output sector_t sector_o
);

  // d*65535 is formed as d*65536 - d, then rounded and divided by 32768.
  function automatic duty_t scale_duty(input phase_t ph, input phase_t cmv);
    logic signed [18:0] d;
    logic [30:0]        t;
    d = DUTY_CENTRE + {{2{ph[PHASE_W-1]}}, ph} + {{2{cmv[PHASE_W-1]}}, cmv};
    t = {d[14:0], 16'd0} - {16'd0, d[14:0]} + DUTY_ROUND;
    if (d <= 19'sd0) begin
      scale_duty = '0;
    end else if (d >= DUTY_FULL_IN) begin
      scale_duty = DUTY_FULL_OUT;
    end else begin
      scale_duty = t[30:15];
    end
  endfunction

  logic    v_r;
  duty_t   da_r;
  duty_t   db_r;
  duty_t   dc_r;
  sector_t sect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r   <= scale_duty(pa, cm);
      db_r   <= scale_duty(pb, cm);
      dc_r   <= scale_duty(pc, cm);
      sect_r <= sector;
    end
  end

  assign out_vld  = v_r;
  assign duty_a   = da_r;
  assign duty_b   = db_r;
  assign duty_c   = dc_r;
  assign sector_o = sect_r;

endmodule

// ----- sv/svpwm_min_max_duty.sv -----
// Space-vector PWM duty generator with min-max common-mode injection.
// An accepted transaction passes the product, phase, common-mode and duty registers
// before its result is on the output. Throughput is one transaction per cycle; the
// four stages move together and all hold while a result waits on the output.
// Synchronous active-low reset clears the stage valid bits only.
module svpwm_min_max_duty import svmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  svmm_in_if.sink     in_ch,
  svmm_out_if.source  out_ch
);

  logic    en;
  logic    v2;
  logic    v3;
  phase_t  pa2;
  phase_t  pb2;
  phase_t  pc2;
  sector_t sect2;
  phase_t  pa3;
  phase_t  pb3;
  phase_t  pc3;
  phase_t  cm3;
  sector_t sect3;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  svmm_clarke u_clarke (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .alpha   (in_ch.alpha_voltage),
    .beta    (in_ch.beta_voltage),
    .out_vld (v2),
    .pa      (pa2),
    .pb      (pb2),
    .pc      (pc2),
    .sector  (sect2)
  );

  svmm_cm u_cm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v2),
    .pa       (pa2),
    .pb       (pb2),
    .pc       (pc2),
    .sector   (sect2),
    .out_vld  (v3),
    .pa_o     (pa3),
    .pb_o     (pb3),
    .pc_o     (pc3),
    .cm_o     (cm3),
    .sector_o (sect3)
  );

  svmm_duty u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3),
    .pa       (pa3),
    .pb       (pb3),
    .pc       (pc3),
    .cm       (cm3),
    .sector   (sect3),
    .out_vld  (out_ch.valid),
    .duty_a   (out_ch.duty_phase_a),
    .duty_b   (out_ch.duty_phase_b),
    .duty_c   (out_ch.duty_phase_c),
    .sector_o (out_ch.sector_number)
  );

endmodule

// ----- sv/svmm_checker.sv -----
// Port-level checker for the SVPWM duty generator and its bind to the top level.
// Depends on svmm_pkg and on svpwm_min_max_duty.
module svmm_checker import svmm_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input duty_t   duty_a,
  input duty_t   duty_b,
  input duty_t   duty_c,
  input sector_t sector
);

  // A stalled result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
      && $stable(duty_c) && $stable(sector))
    else $error("result changed while stalled");

  // The zero vector always yields centered duties.
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sector == SECT_ZERO |->
      duty_a == 16'd32768 && duty_b == 16'd32768 && duty_c == 16'd32768)
    else $error("zero vector with off-center duty");

  // The input is never refused unless a result is stalled.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused without output stall");

  // When nothing stalls, an accepted transaction reaches the output once it has passed every stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind svpwm_min_max_duty svmm_checker u_svmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .duty_a    (out_ch.duty_phase_a),
  .duty_b    (out_ch.duty_phase_b),
  .duty_c    (out_ch.duty_phase_c),
  .sector    (out_ch.sector_number)
);
